@@ hw/rtl/fmbq_pkg.sv @@
// Shared types and constants for the front/middle/back queue.
`default_nettype none

package fmbq_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_DATA_WIDTH = 32;
  localparam int WORD_WIDTH     = 32;  // width of the value and popped ports
  localparam int OCC_WIDTH      = 7;   // width of the occupancy port
  localparam int ACTION_WIDTH   = 3;

  typedef enum logic [ACTION_WIDTH-1:0] {
    ACT_PUSH_FRONT  = 3'd0,
    ACT_PUSH_MIDDLE = 3'd1,
    ACT_PUSH_BACK   = 3'd2,
    ACT_POP_FRONT   = 3'd3,
    ACT_POP_MIDDLE  = 3'd4,
    ACT_POP_BACK    = 3'd5
  } action_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic ins;  // open a gap at pos, shift higher cells up, load word
    logic rem;  // close the gap at pos, shift higher cells down
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/fmbq_cell.sv @@
// One storage cell of the queue chain: holds, loads, or takes a neighbour's word.
`default_nettype none

module fmbq_cell #(
  parameter int DATA_WIDTH  = fmbq_pkg::DEF_DATA_WIDTH,
  parameter int INDEX_WIDTH = 6,
  parameter int INDEX       = 0
) (
  input  wire logic                   clk,
  input  wire fmbq_pkg::cell_ctrl_t   ctrl,
  input  wire logic [INDEX_WIDTH-1:0] pos,
  input  wire logic [DATA_WIDTH-1:0]  word,
  input  wire logic [DATA_WIDTH-1:0]  left,
  input  wire logic [DATA_WIDTH-1:0]  right,
  output logic      [DATA_WIDTH-1:0]  data,
  output logic      [DATA_WIDTH-1:0]  sel_data
);

  localparam logic [INDEX_WIDTH-1:0] MyIndex = INDEX_WIDTH'(INDEX);

  logic at_pos;
  logic above_pos;

  assign at_pos    = (pos == MyIndex);
  assign above_pos = (MyIndex > pos);

  // Only the cell at pos shows its word on the extraction bus.
  assign sel_data = at_pos ? data : '0;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (above_pos) begin
        data <= left;
      end else if (at_pos) begin
        data <= word;
      end
    end else if (ctrl.rem) begin
      if (above_pos || at_pos) begin
        data <= right;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/front_middle_back_queue_unit.sv @@
// Top level of the front/middle/back queue: control, cell chain, result register.
//
// Usage
//   Requests arrive on the input channel (in_valid/in_ready) as an action code
//   and a data word: push or pop at the front, middle or back. Each request
//   yields exactly one result on the output channel (out_valid/out_ready):
//   the popped word, empty/full flags and the occupancy after the request.
//   Middle push inserts at index count/2; middle pop removes (count-1)/2.
// Throughput and timing
//   One request per cycle while out_ready is high. The result appears in the
//   cycle after acceptance. All cells shift in parallel, so the cost of an
//   insert or remove does not depend on position; the extraction bus (an OR
//   over all cells) and the position compare in each cell set the cycle time.
// Reset
//   rst clears the element count and the result valid; cell contents are
//   left as they are and are never read before being written.
// Stalls
//   The result register holds while out_ready is low; a new request is taken
//   in the same cycle the held result leaves, otherwise in_ready stays low.
//   Pushes into a full queue and pops from an empty one change nothing and
//   are flagged; unused action codes report the occupancy only.
`default_nettype none

module front_middle_back_queue_unit #(
  parameter int CAPACITY   = fmbq_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = fmbq_pkg::DEF_DATA_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [fmbq_pkg::ACTION_WIDTH-1:0] action,
  input  wire logic signed [fmbq_pkg::WORD_WIDTH-1:0] value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [fmbq_pkg::WORD_WIDTH-1:0] popped,
  output logic                                   was_empty,
  output logic                                   was_full,
  output logic      [fmbq_pkg::OCC_WIDTH-1:0]    occupancy
);

  localparam int CW = $clog2(CAPACITY + 1);  // count width
  localparam int IW = $clog2(CAPACITY);      // cell index width
  localparam int WW = fmbq_pkg::WORD_WIDTH;
  localparam int OW = fmbq_pkg::OCC_WIDTH;

  logic accept;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] pos_wide;
  logic [IW-1:0] pos;
  logic is_full;
  logic is_empty;
  logic empty_hit;
  logic full_hit;
  logic take_pop;
  fmbq_pkg::cell_ctrl_t ctrl;

  logic [DATA_WIDTH+WW-1:0] word_ext;
  logic [DATA_WIDTH-1:0]    word;
  logic [DATA_WIDTH-1:0]    cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0]    cell_sel  [CAPACITY];
  logic [DATA_WIDTH-1:0]    extract;
  logic [DATA_WIDTH+WW-1:0] extract_ext;
  logic [CW+OW-1:0]         occ_ext;

  // Output register frees as its result is taken.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign is_full  = (count == CW'(CAPACITY));
  assign is_empty = (count == '0);

  // Low DATA_WIDTH bits of the request word are kept.
  assign word_ext = {{DATA_WIDTH{1'b0}}, value};
  assign word     = word_ext[DATA_WIDTH-1:0];

  // Decode: position, cell command, flags, next count.
  always_comb begin
    pos_wide   = '0;
    ctrl.ins   = 1'b0;
    ctrl.rem   = 1'b0;
    empty_hit  = 1'b0;
    full_hit   = 1'b0;
    take_pop   = 1'b0;
    count_next = count;
    case (fmbq_pkg::action_t'(action))
      fmbq_pkg::ACT_PUSH_FRONT, fmbq_pkg::ACT_PUSH_MIDDLE, fmbq_pkg::ACT_PUSH_BACK: begin
        if (fmbq_pkg::action_t'(action) == fmbq_pkg::ACT_PUSH_MIDDLE) begin
          pos_wide = count >> 1;
        end else if (fmbq_pkg::action_t'(action) == fmbq_pkg::ACT_PUSH_BACK) begin
          pos_wide = count;
        end
        if (is_full) begin
          full_hit = 1'b1;
        end else begin
          ctrl.ins   = accept;
          count_next = count + CW'(1);
        end
      end
      fmbq_pkg::ACT_POP_FRONT, fmbq_pkg::ACT_POP_MIDDLE, fmbq_pkg::ACT_POP_BACK: begin
        if (fmbq_pkg::action_t'(action) == fmbq_pkg::ACT_POP_MIDDLE) begin
          pos_wide = (count - CW'(1)) >> 1;
        end else if (fmbq_pkg::action_t'(action) == fmbq_pkg::ACT_POP_BACK) begin
          pos_wide = count - CW'(1);
        end
        if (is_empty) begin
          empty_hit = 1'b1;
        end else begin
          ctrl.rem   = accept;
          take_pop   = 1'b1;
          count_next = count - CW'(1);
        end
      end
      default: begin
        // unused codes: nothing changes
      end
    endcase
  end

  assign pos = pos_wide[IW-1:0];

  // Cell chain: each cell sees its left and right neighbour.
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;
    if (gi == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_data[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_data[gi+1];
    end
    fmbq_cell #(
      .DATA_WIDTH  (DATA_WIDTH),
      .INDEX_WIDTH (IW),
      .INDEX       (gi)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .pos      (pos),
      .word     (word),
      .left     (left_w),
      .right    (right_w),
      .data     (cell_data[gi]),
      .sel_data (cell_sel[gi])
    );
  end

  // Extraction bus: at most one cell drives a non-zero word.
  always_comb begin
    extract = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      extract = extract | cell_sel[i];
    end
  end

  assign extract_ext = {{WW{1'b0}}, extract};
  assign occ_ext     = {{OW{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      popped    <= take_pop ? extract_ext[WW-1:0] : '0;
      was_empty <= empty_hit;
      was_full  <= full_hit;
      occupancy <= occ_ext[OW-1:0];
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_front_middle_back_queue_unit.sv @@
// Self-checking testbench for the front/middle/back queue unit.
module tb_front_middle_back_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WW             = fmbq_pkg::WORD_WIDTH;
  localparam int AW             = fmbq_pkg::ACTION_WIDTH;
  localparam int OW             = fmbq_pkg::OCC_WIDTH;
  localparam int CAPACITY       = fmbq_pkg::DEF_CAPACITY;
  localparam int RX_HOLD_CYCLES = 400;  // long receiver hold-off, fills the result stage
  localparam int MAX_REPORTS    = 50;   // keeps the log readable on a badly broken build

  // Action codes with no operation behind them: the block reports occupancy only.
  localparam logic [AW-1:0] ACT_RESERVED_LO = 3'd6;
  localparam logic [AW-1:0] ACT_RESERVED_HI = 3'd7;

  typedef struct packed {
    logic signed [WW-1:0] popped;
    logic                 was_empty;
    logic                 was_full;
    logic [OW-1:0]        occupancy;
  } op_result_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [AW-1:0]          action;
  logic signed [WW-1:0]   value;
  logic                   out_valid;
  logic                   out_ready;
  logic signed [WW-1:0]   popped;
  logic                   was_empty;
  logic                   was_full;
  logic [OW-1:0]          occupancy;

  // Shadow of the queue contents, front at index 0.
  logic [WW-1:0] model_words[$];
  // Results still owed by the block, oldest first.
  op_result_t    pending_results[$];

  int unsigned requests_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned full_drops      = 0;
  int unsigned empty_pops      = 0;
  int unsigned peak_occupancy  = 0;
  int unsigned fail_count      = 0;

  // Sender and receiver idling controls.
  bit          tx_gaps_on  = 1'b0;
  int unsigned burst_left  = 0;
  bit          rx_stall_on = 1'b0;
  bit          rx_hold_req = 1'b0;
  logic [15:0] stall_pattern;
  int unsigned pattern_age = 0;

  front_middle_back_queue_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .popped    (popped),
    .was_empty (was_empty),
    .was_full  (was_full),
    .occupancy (occupancy)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Applies one request to the shadow queue and returns what the block should report.
  function automatic op_result_t apply_queue_op(input logic [AW-1:0] act,
                                                input logic [WW-1:0] word);
    op_result_t  res;
    int unsigned n;
    int unsigned pos;
    res = '0;
    n   = model_words.size();
    case (act)
      fmbq_pkg::ACT_PUSH_FRONT, fmbq_pkg::ACT_PUSH_MIDDLE, fmbq_pkg::ACT_PUSH_BACK: begin
        if (n >= CAPACITY) begin
          res.was_full = 1'b1;   // dropped, queue untouched
        end else begin
          pos = (act == fmbq_pkg::ACT_PUSH_FRONT) ? 0 :
                (act == fmbq_pkg::ACT_PUSH_MIDDLE) ? n / 2 : n;
          model_words.insert(pos, word);
        end
      end
      fmbq_pkg::ACT_POP_FRONT, fmbq_pkg::ACT_POP_MIDDLE, fmbq_pkg::ACT_POP_BACK: begin
        if (n == 0) begin
          res.was_empty = 1'b1;
        end else begin
          pos = (act == fmbq_pkg::ACT_POP_FRONT) ? 0 :
                (act == fmbq_pkg::ACT_POP_MIDDLE) ? (n - 1) / 2 : n - 1;
          res.popped = model_words[pos];
          model_words.delete(pos);
        end
      end
      default: ;  // reserved codes leave everything alone
    endcase
    res.occupancy = OW'(model_words.size());
    return res;
  endfunction

  // Data words: mostly random, with a fair share of the extremes.
  function automatic logic [WW-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, {(WW-1){1'b0}}};
      3:       return {1'b0, {(WW-1){1'b1}}};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [AW-1:0] pick_push();
    return fmbq_pkg::action_t'($urandom_range(fmbq_pkg::ACT_PUSH_FRONT,
                                              fmbq_pkg::ACT_PUSH_BACK));
  endfunction

  function automatic logic [AW-1:0] pick_pop();
    return fmbq_pkg::action_t'($urandom_range(fmbq_pkg::ACT_POP_FRONT,
                                              fmbq_pkg::ACT_POP_BACK));
  endfunction

  // push_pct steers occupancy: high values grow the queue, low values drain it.
  function automatic logic [AW-1:0] pick_action(input int unsigned push_pct);
    if ($urandom_range(0, 99) < 3)
      return $urandom_range(0, 1) ? ACT_RESERVED_HI : ACT_RESERVED_LO;
    if ($urandom_range(0, 99) < push_pct)
      return pick_push();
    return pick_pop();
  endfunction

  // Offers one request and returns at the edge where it is taken.
  task automatic send_request(input logic [AW-1:0] act,
                              input logic [WW-1:0] word);
    int unsigned gap;
    if (tx_gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    action   <= act;
    value    <= word;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_results.insert(pending_results.size(), apply_queue_op(act, word));
    if (burst_left != 0) burst_left--;
    if (act != ACT_RESERVED_LO && act != ACT_RESERVED_HI) requests_sent++;
    if (model_words.size() > peak_occupancy) peak_occupancy = model_words.size();
  endtask

  // Sender pause: nothing offered until every owed result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Empty pops, reserved codes, extremes of the data word, every push and pop position.
  task automatic test_directed_cases();
    send_request(fmbq_pkg::ACT_POP_FRONT, '0);
    send_request(fmbq_pkg::ACT_POP_MIDDLE, '1);
    send_request(fmbq_pkg::ACT_POP_BACK, 32'h1234_5678);
    send_request(ACT_RESERVED_LO, 32'hDEAD_BEEF);
    send_request(ACT_RESERVED_HI, '0);
    send_request(fmbq_pkg::ACT_PUSH_BACK, 32'h7FFF_FFFF);
    send_request(fmbq_pkg::ACT_PUSH_FRONT, 32'h8000_0000);
    send_request(fmbq_pkg::ACT_PUSH_MIDDLE, 32'h0000_0000);
    send_request(fmbq_pkg::ACT_PUSH_MIDDLE, 32'hFFFF_FFFF);
    send_request(fmbq_pkg::ACT_PUSH_BACK, 32'h5555_5555);
    send_request(fmbq_pkg::ACT_PUSH_FRONT, 32'hAAAA_AAAA);
    send_request(ACT_RESERVED_HI, 32'hFFFF_FFFF);  // occupancy only, queue not empty
    send_request(fmbq_pkg::ACT_POP_MIDDLE, '0);
    send_request(fmbq_pkg::ACT_POP_MIDDLE, '0);
    send_request(fmbq_pkg::ACT_POP_FRONT, '0);
    send_request(fmbq_pkg::ACT_POP_BACK, '0);
    send_request(fmbq_pkg::ACT_POP_MIDDLE, '0);
    send_request(fmbq_pkg::ACT_POP_MIDDLE, '0);              // last element goes via the middle
    send_request(fmbq_pkg::ACT_POP_FRONT, '0);
    send_request(fmbq_pkg::ACT_PUSH_MIDDLE, 32'h0000_0001);  // middle push into an empty queue
    send_request(fmbq_pkg::ACT_POP_BACK, '0);
  endtask

  // Fill to capacity, push past it, then empty it and pop past that.
  task automatic test_fill_and_drain();
    while (model_words.size() < CAPACITY)
      send_request(pick_push(), pick_word());
    repeat (4) send_request(pick_push(), pick_word());
    while (model_words.size() != 0)
      send_request(pick_pop(), pick_word());
    repeat (3) send_request(pick_pop(), pick_word());
  endtask

  // Random requests in growing, shrinking and balanced phases so full and empty recur.
  task automatic test_random_phases(input int unsigned count);
    int unsigned target;
    int unsigned phase_left;
    int unsigned push_pct;
    target     = requests_sent + count;
    phase_left = 0;
    push_pct   = 50;
    while (requests_sent < target) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 50;
        endcase
        phase_left = $urandom_range(20, 120);
      end
      send_request(pick_action(push_pct), pick_word());
      phase_left--;
    end
  endtask

  // Receiver holds off while requests keep coming back to back, then the sender pauses.
  task automatic test_backpressure();
    tx_gaps_on  = 1'b0;
    rx_hold_req = 1'b1;
    repeat (40) send_request(pick_action(60), pick_word());
    wait_drained();
    tx_gaps_on = 1'b1;
  endtask

  // Receiver: always ready, a rotating stall pattern, or one long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (!rx_stall_on) begin
        out_ready <= 1'b1;
      end else begin
        if (pattern_age == 0) begin
          // never all zero; a quarter of the patterns give stall-free stretches
          stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                      : (16'($urandom) | 16'h0001);
          pattern_age   = $urandom_range(16, 96);
        end
        out_ready     <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        pattern_age--;
      end
    end
  end

  task automatic check_field(input string field, input logic [WW-1:0] want,
                             input logic [WW-1:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $error("%s: expected %h, got %h", field, want, got);
    end
  endtask

  // Every result taken is matched against the oldest owed one.
  always @(posedge clk) begin : result_check
    op_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $error("result with no request outstanding: popped %h occupancy %0d",
                 popped, occupancy);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        results_checked++;
        if (want.was_full) full_drops++;
        if (want.was_empty) empty_pops++;
        check_field("popped", want.popped, popped);
        check_field("was_empty", WW'(want.was_empty), WW'(was_empty));
        check_field("was_full", WW'(want.was_full), WW'(was_full));
        check_field("occupancy", WW'(want.occupancy), WW'(occupancy));
      end
    end
  end

  initial begin
    int unsigned drain_cycles;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    action   <= fmbq_pkg::ACT_PUSH_FRONT;
    value    <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
    test_directed_cases();
    wait_drained();
    test_fill_and_drain();
    wait_drained();
    test_random_phases(1000);
    test_backpressure();
    // full rate on both sides
    tx_gaps_on  = 1'b0;
    rx_stall_on = 1'b0;
    test_random_phases(300);
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
    test_random_phases(250);

    in_valid    <= 1'b0;
    rx_stall_on = 1'b0;
    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < 2000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      fail_count++;
      $error("%0d results never arrived", pending_results.size());
    end

    $display("Covered %0d requests, %0d results checked: %0d pushes dropped when full,",
             requests_sent, results_checked, full_drops);
    $display("%0d pops on an empty queue, peak occupancy %0d.", empty_pops, peak_occupancy);
    if (fail_count == 0) begin
      $display("** front_middle_back_queue_unit: PASSED **");
    end else begin
      $display("** front_middle_back_queue_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #2_000_000;
    $display("** front_middle_back_queue_unit: FAILED **");
    $finish;
  end

endmodule
